// File: rtl/core/shamd_pkg.sv
// Package for the SHA-256 message digest unit: state encoding, round and
// initial hash constants, and the SHA-256 sigma functions.
// No dependencies.
`default_nettype none

package shamd_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_FOLD  = 5'b00100,
        S_PAD   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] POS_LEN     = 6'd56;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] ROUND_LAST  = 6'd63;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sigma0(input t_word a);
        return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word e);
        return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_message_digest_unit.sv
// SHA-256 message digest unit, fed one byte per beat.
// Depends on shamd_pkg (state encoding, round constants, sigma functions).
//
// Usage:
//   Input channel (i_valid / o_stall): each beat carries i_data_byte, a
//   presence flag i_byte_present and an end marker i_end_of_message. A beat
//   with no byte and no end is dropped. A beat with no byte but the end
//   marker closes the message (empty message when nothing came before).
//   Output channel (o_valid / i_stall): one beat per message, the 256-bit
//   digest as four 64-bit words, H0 in the upper half of o_digest_part0.
//   The 64th byte of a block starts the compression: 64 rounds through one
//   shared round unit, one round a cycle, then a fold into the chain value,
//   with o_stall high throughout. At the end marker the padding bytes (0x80,
//   zeros, 64-bit bit length) are fed through the same byte path one a cycle
//   up to the block end, then compressed; a message whose tail leaves fewer
//   than nine free bytes takes an extra padding block. After the last fold
//   the unit enters the done state and loads the digest into the output
//   register as soon as that register is free.
//   Reset (synchronous, active low) restores the initial hash values and
//   clears the byte count. When the receiver stalls, the digest is held in
//   the output register; the unit keeps taking beats of the next message and
//   only waits if a second digest is ready before the first is taken.
`default_nettype none

module sha256_message_digest_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [63:0] o_digest_part0,
    output      logic [63:0] o_digest_part1,
    output      logic [63:0] o_digest_part2,
    output      logic [63:0] o_digest_part3
);

    shamd_pkg::t_state r_state, n_state;

    // Chain value, working variables and the 16-word schedule window.
    // The window is a shift line: bytes and expanded words enter at the top,
    // the oldest word (w[t]) sits at the bottom.
    shamd_pkg::t_word r_chain [8];
    shamd_pkg::t_word r_work  [8];
    shamd_pkg::t_word r_sched [16];
    logic [23:0]      r_word;        // partial word being packed

    logic [63:0] r_byte_count;       // message bytes, wraps at 2^64
    logic [5:0]  r_pos;              // byte offset in the current block
    logic [5:0]  r_round;            // round index
    logic [63:0] r_len;              // bit length, shifted out a byte at a time

    logic r_pad_first;               // next pad byte is the 0x80 marker
    logic r_len_ok;                  // length field goes into this block
    logic r_pad_pending;             // resume padding after the fold
    logic r_final;                   // this block closes the message

    logic        r_out_valid;
    logic [63:0] r_digest [4];

    logic              in_acc, take_msg, byte_take, blk_full, out_free, pad_last;
    logic [7:0]        pad_byte, byte_val;
    shamd_pkg::t_word  t1, t2, new_w, a_v, e_v, w_t;

    assign o_stall = (r_state != shamd_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_digest_part0 = r_digest[0];
    assign o_digest_part1 = r_digest[1];
    assign o_digest_part2 = r_digest[2];
    assign o_digest_part3 = r_digest[3];

    always_comb begin
        in_acc   = i_valid && (r_state == shamd_pkg::S_IDLE);
        take_msg = in_acc && i_byte_present;
        out_free = !r_out_valid || !i_stall;

        // Pad byte: marker first, then zeros, then the length in the last
        // eight bytes of the closing block.
        if (r_pad_first) begin
            pad_byte = shamd_pkg::PAD_MARK;
        end else if (r_len_ok && (r_pos >= shamd_pkg::POS_LEN)) begin
            pad_byte = r_len[63:56];
        end else begin
            pad_byte = 8'h00;
        end
        // Length fits only if the marker landed before the length field.
        pad_last = !r_pad_first && r_len_ok;

        byte_take = take_msg || (r_state == shamd_pkg::S_PAD);
        byte_val  = (r_state == shamd_pkg::S_PAD) ? pad_byte : i_data_byte;
        blk_full  = byte_take && (r_pos == shamd_pkg::POS_LAST);

        // Shared round unit
        a_v = r_work[0];
        e_v = r_work[4];
        w_t = r_sched[0];
        t1 = r_work[7] + shamd_pkg::big_sigma1(e_v)
           + ((e_v & r_work[5]) ^ (~e_v & r_work[6]))
           + shamd_pkg::K_ROUND[r_round] + w_t;
        t2 = shamd_pkg::big_sigma0(a_v)
           + ((a_v & r_work[1]) ^ (a_v & r_work[2]) ^ (r_work[1] & r_work[2]));
        new_w = shamd_pkg::small_sigma1(r_sched[14]) + r_sched[9]
              + shamd_pkg::small_sigma0(r_sched[1]) + r_sched[0];

        n_state = r_state;
        case (r_state)
            shamd_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (blk_full) begin
                        n_state = shamd_pkg::S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = shamd_pkg::S_PAD;
                    end
                end
            end
            shamd_pkg::S_ROUND: begin
                if (r_round == shamd_pkg::ROUND_LAST) begin
                    n_state = shamd_pkg::S_FOLD;
                end
            end
            shamd_pkg::S_FOLD: begin
                if (r_final) begin
                    n_state = shamd_pkg::S_DONE;
                end else if (r_pad_pending) begin
                    n_state = shamd_pkg::S_PAD;
                end else begin
                    n_state = shamd_pkg::S_IDLE;
                end
            end
            shamd_pkg::S_PAD: begin
                if (blk_full) begin
                    n_state = shamd_pkg::S_ROUND;
                end
            end
            shamd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = shamd_pkg::S_IDLE;
                end
            end
            default: n_state = shamd_pkg::S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= shamd_pkg::S_IDLE;
            r_byte_count  <= '0;
            r_pos         <= '0;
            r_round       <= '0;
            r_pad_first   <= 1'b0;
            r_len_ok      <= 1'b0;
            r_pad_pending <= 1'b0;
            r_final       <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= shamd_pkg::H_INIT[i];
            end
        end else begin
            r_state <= n_state;

            if (take_msg) begin
                r_byte_count <= r_byte_count + 64'd1;
            end
            if (byte_take) begin
                r_pos <= r_pos + 6'd1;
            end
            if (r_state == shamd_pkg::S_ROUND) begin
                r_round <= r_round + 6'd1;
            end

            if (in_acc && i_end_of_message) begin
                r_pad_first   <= 1'b1;
                r_pad_pending <= blk_full;
            end

            if (r_state == shamd_pkg::S_PAD) begin
                r_pad_first <= 1'b0;
                if (r_pad_first) begin
                    r_len <= {r_byte_count[60:0], 3'b000};
                end else if (r_len_ok && (r_pos >= shamd_pkg::POS_LEN)) begin
                    r_len <= {r_len[55:0], 8'h00};
                end
                if (blk_full) begin
                    r_final       <= pad_last;
                    r_pad_pending <= !pad_last;
                    r_len_ok      <= 1'b1;   // extra block always ends in length
                end else if (r_pad_first) begin
                    r_len_ok <= (r_pos < shamd_pkg::POS_LEN);
                end
            end

            if (r_state == shamd_pkg::S_FOLD) begin
                r_pad_pending <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end

            if ((r_state == shamd_pkg::S_DONE) && out_free) begin
                r_final      <= 1'b0;
                r_byte_count <= '0;
                r_out_valid  <= 1'b1;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= shamd_pkg::H_INIT[i];
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: byte packing, schedule window, working variables, digest
    always_ff @(posedge i_clk) begin
        if (byte_take) begin
            r_word <= {r_word[15:0], byte_val};
            if (r_pos[1:0] == 2'b11) begin
                for (int j = 0; j < 15; j++) begin
                    r_sched[j] <= r_sched[j + 1];
                end
                r_sched[15] <= {r_word, byte_val};
            end
        end else if (r_state == shamd_pkg::S_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                r_sched[j] <= r_sched[j + 1];
            end
            r_sched[15] <= new_w;
        end

        if (blk_full) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (r_state == shamd_pkg::S_ROUND) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
        end

        if ((r_state == shamd_pkg::S_DONE) && out_free) begin
            for (int j = 0; j < 4; j++) begin
                r_digest[j] <= {r_chain[2 * j], r_chain[2 * j + 1]};
            end
        end
    end

    // Checks
    a_round_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamd_pkg::S_ROUND) && (r_round == shamd_pkg::ROUND_LAST)
        |=> (r_state == shamd_pkg::S_FOLD))
        else $error("last round did not lead to the fold");

    a_fold_on_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamd_pkg::S_FOLD) |-> (r_pos == 6'd0) && (r_round == 6'd0))
        else $error("fold away from a block boundary");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamd_pkg::S_IDLE) |-> !r_final && !r_pad_pending)
        else $error("idle with padding work still pending");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamd_pkg::S_DONE) && out_free |=> o_valid)
        else $error("digest not presented after completion");

endmodule

`default_nettype wire
